[rtl/rsc_pkg.sv]
// Shared types, constants and symbol table functions for the RSA symbol cipher.
package rsc_pkg;

    localparam int DATA_W   = 32;
    localparam int MOD_W    = 32;
    localparam int CODE_W   = 7;
    localparam int STEP_W   = $clog2(DATA_W);
    localparam int ADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_EXPONENT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MODULUS   = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NONE  = 7'd0;
    localparam logic [CODE_W-1:0] CODE_FIRST = 7'd2;
    localparam logic [CODE_W-1:0] CODE_LAST  = 7'd66;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_REDUCE,
        ST_BASE,
        ST_CHECK,
        ST_MUL,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_reduce;
        logic set_base;
        logic zero_acc;
        logic load_mul;
        logic step;
        logic update;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic char_ok;
        logic mod_small;
        logic cnt_last;
        logic exp_zero;
    } t_dp_status;

    function automatic logic [CODE_W-1:0] char_to_code(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        case (c) inside
            [8'h62:8'h7A]: t = c - 8'h62 + 8'd2;
            8'h61:         t = 8'd27;
            8'h20:         t = 8'd28;
            [8'h41:8'h5A]: t = c - 8'h41 + 8'd29;
            8'h2C:         t = 8'd55;
            8'h2E:         t = 8'd56;
            8'h40:         t = 8'd57;
            8'h21:         t = 8'd58;
            8'h3F:         t = 8'd59;
            8'h29:         t = 8'd60;
            8'h28:         t = 8'd61;
            8'h2A:         t = 8'd62;
            8'h2D:         t = 8'd63;
            8'h5F:         t = 8'd64;
            8'h25:         t = 8'd65;
            8'h3A:         t = 8'd66;
            default:       t = 8'd0;
        endcase
        return t[CODE_W-1:0];
    endfunction

    function automatic logic [7:0] code_to_char(input logic [CODE_W-1:0] code);
        logic [7:0] k;
        logic [7:0] c;
        k = {1'b0, code};
        c = 8'd0;
        case (k) inside
            [8'd2:8'd26]:  c = k - 8'd2 + 8'h62;
            8'd27:         c = 8'h61;
            8'd28:         c = 8'h20;
            [8'd29:8'd54]: c = k - 8'd29 + 8'h41;
            8'd55:         c = 8'h2C;
            8'd56:         c = 8'h2E;
            8'd57:         c = 8'h40;
            8'd58:         c = 8'h21;
            8'd59:         c = 8'h3F;
            8'd60:         c = 8'h29;
            8'd61:         c = 8'h28;
            8'd62:         c = 8'h2A;
            8'd63:         c = 8'h2D;
            8'd64:         c = 8'h5F;
            8'd65:         c = 8'h25;
            8'd66:         c = 8'h3A;
            default:       c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/rsc_modmul.sv]
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle while i_step is high.
module rsc_modmul (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [rsc_pkg::MOD_W-1:0]  i_a,
    input  logic [rsc_pkg::DATA_W-1:0] i_b,
    input  logic [rsc_pkg::MOD_W-1:0]  i_m,
    output logic [rsc_pkg::MOD_W-1:0]  o_p
);

    logic [rsc_pkg::MOD_W-1:0]  r_a;
    logic [rsc_pkg::DATA_W-1:0] r_b;
    logic [rsc_pkg::MOD_W-1:0]  r_acc;
    logic [rsc_pkg::MOD_W-1:0]  n_acc;

    logic [rsc_pkg::MOD_W+1:0] t;
    logic [rsc_pkg::MOD_W+1:0] m1;
    logic [rsc_pkg::MOD_W+1:0] m2;
    logic [rsc_pkg::MOD_W+1:0] d1;
    logic [rsc_pkg::MOD_W+1:0] d2;

    always_comb begin
        t  = {1'b0, r_acc, 1'b0} + {2'b00, (r_b[rsc_pkg::DATA_W-1] ? r_a : '0)};
        m1 = {2'b00, i_m};
        m2 = {1'b0, i_m, 1'b0};
        d1 = t - m1;
        d2 = t - m2;
        if (t >= m2) begin
            n_acc = d2[rsc_pkg::MOD_W-1:0];
        end else if (t >= m1) begin
            n_acc = d1[rsc_pkg::MOD_W-1:0];
        end else begin
            n_acc = t[rsc_pkg::MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_step) begin
            r_b   <= {r_b[rsc_pkg::DATA_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_p = r_acc;

endmodule

[rtl/rsc_datapath.sv]
// Datapath: operand registers, two modular multipliers, step counter and result register.
module rsc_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsc_pkg::t_dp_cmd           i_cmd,
    output rsc_pkg::t_dp_status        o_status,
    input  logic [rsc_pkg::DATA_W-1:0] i_data_in,
    input  logic                       i_direction,
    input  logic [rsc_pkg::DATA_W-1:0] i_exponent,
    input  logic [rsc_pkg::MOD_W-1:0]  i_modulus,
    output logic                       o_result_valid,
    output logic [rsc_pkg::DATA_W-1:0] o_result_value
);

    logic [rsc_pkg::DATA_W-1:0] r_data;
    logic [rsc_pkg::DATA_W-1:0] r_exp;
    logic [rsc_pkg::MOD_W-1:0]  r_base;
    logic [rsc_pkg::MOD_W-1:0]  r_acc;
    logic [rsc_pkg::STEP_W-1:0] r_cnt;
    logic                       r_out_valid;
    logic [rsc_pkg::DATA_W-1:0] r_out_value;

    logic [rsc_pkg::CODE_W-1:0] code;
    logic [rsc_pkg::DATA_W-1:0] reduce_src;
    logic [rsc_pkg::DATA_W-1:0] base_ext;
    logic                       sq_load;
    logic [rsc_pkg::MOD_W-1:0]  sq_a;
    logic [rsc_pkg::DATA_W-1:0] sq_b;
    logic [rsc_pkg::MOD_W-1:0]  sq_p;
    logic [rsc_pkg::MOD_W-1:0]  ml_p;
    logic                       code_hit;
    logic                       n_out_valid;
    logic [rsc_pkg::DATA_W-1:0] n_out_value;

    always_comb begin
        code       = rsc_pkg::char_to_code(r_data[7:0]);
        reduce_src = (i_direction == rsc_pkg::DIR_DECRYPT) ? r_data : rsc_pkg::DATA_W'(code);
        base_ext   = rsc_pkg::DATA_W'(r_base);
        sq_load    = i_cmd.load_reduce | i_cmd.load_mul;
        sq_a       = i_cmd.load_reduce ? rsc_pkg::MOD_W'(1) : r_base;
        sq_b       = i_cmd.load_reduce ? reduce_src : base_ext;

        o_status.char_ok   = (i_direction == rsc_pkg::DIR_DECRYPT) ||
                             ((r_data[rsc_pkg::DATA_W-1:8] == '0) && (code != rsc_pkg::CODE_NONE));
        o_status.mod_small = i_modulus < rsc_pkg::MOD_W'(2);
        o_status.cnt_last  = r_cnt == rsc_pkg::STEP_W'(rsc_pkg::DATA_W - 1);
        o_status.exp_zero  = r_exp == '0;

        code_hit = (r_acc >= rsc_pkg::MOD_W'(rsc_pkg::CODE_FIRST)) &&
                   (r_acc <= rsc_pkg::MOD_W'(rsc_pkg::CODE_LAST));
        if (i_direction == rsc_pkg::DIR_DECRYPT) begin
            n_out_valid = i_cmd.emit & code_hit;
            n_out_value = rsc_pkg::DATA_W'(rsc_pkg::code_to_char(r_acc[rsc_pkg::CODE_W-1:0]));
        end else begin
            n_out_valid = i_cmd.emit;
            n_out_value = rsc_pkg::DATA_W'(r_acc);
        end
    end

    rsc_modmul u_square (
        .i_clk  (i_clk),
        .i_load (sq_load),
        .i_step (i_cmd.step),
        .i_a    (sq_a),
        .i_b    (sq_b),
        .i_m    (i_modulus),
        .o_p    (sq_p)
    );

    rsc_modmul u_multiply (
        .i_clk  (i_clk),
        .i_load (i_cmd.load_mul),
        .i_step (i_cmd.step),
        .i_a    (r_acc),
        .i_b    (base_ext),
        .i_m    (i_modulus),
        .o_p    (ml_p)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data <= i_data_in;
            r_exp  <= i_exponent;
        end else if (i_cmd.update) begin
            r_exp  <= {1'b0, r_exp[rsc_pkg::DATA_W-1:1]};
        end
        if (i_cmd.set_base) begin
            r_base <= sq_p;
        end else if (i_cmd.update) begin
            r_base <= sq_p;
        end
        if (i_cmd.set_base) begin
            r_acc <= rsc_pkg::MOD_W'(1);
        end else if (i_cmd.zero_acc) begin
            r_acc <= '0;
        end else if (i_cmd.update && r_exp[0]) begin
            r_acc <= ml_p;
        end
        if (n_out_valid) begin
            r_out_value <= n_out_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (sq_load) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + rsc_pkg::STEP_W'(1);
            end
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_value = r_out_value;

endmodule

[rtl/rsc_ctrl.sv]
// Controller state machine sequencing reduction, square-and-multiply and result output.
module rsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rsc_pkg::t_dp_status i_status,
    output rsc_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    rsc_pkg::t_state r_state;
    rsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            rsc_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rsc_pkg::ST_PREP;
                end
            end
            rsc_pkg::ST_PREP: begin
                if (!i_status.char_ok) begin
                    n_state = rsc_pkg::ST_IDLE;
                end else if (i_status.mod_small) begin
                    o_cmd.zero_acc = 1'b1;
                    n_state        = rsc_pkg::ST_FINISH;
                end else begin
                    o_cmd.load_reduce = 1'b1;
                    n_state           = rsc_pkg::ST_REDUCE;
                end
            end
            rsc_pkg::ST_REDUCE: begin
                o_cmd.step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = rsc_pkg::ST_BASE;
                end
            end
            rsc_pkg::ST_BASE: begin
                o_cmd.set_base = 1'b1;
                n_state        = rsc_pkg::ST_CHECK;
            end
            rsc_pkg::ST_CHECK: begin
                if (i_status.exp_zero) begin
                    n_state = rsc_pkg::ST_FINISH;
                end else begin
                    o_cmd.load_mul = 1'b1;
                    n_state        = rsc_pkg::ST_MUL;
                end
            end
            rsc_pkg::ST_MUL: begin
                o_cmd.step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = rsc_pkg::ST_UPDATE;
                end
            end
            rsc_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = rsc_pkg::ST_CHECK;
            end
            rsc_pkg::ST_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = rsc_pkg::ST_IDLE;
            end
            default: begin
                n_state = rsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != rsc_pkg::ST_IDLE;

endmodule

[rtl/textbook_rsa_symbol_cipher.sv]
// Top level of the per-symbol RSA cipher: register port, controller and datapath.
// A request is taken when start is high and busy is low; busy stays high until the
// request is done. The base is first reduced mod modulus, then each exponent bit up
// to the highest set one takes one pass of squaring and multiplying, which run side
// by side in two bit-serial modular multipliers, one bit per cycle while they step.
// A character outside the table, or a decrypted value that is no table code, gives
// no result. A result is shown for exactly one cycle on o_result_valid as busy drops;
// the receiver cannot stall it, and a new request may start in that same cycle.
module textbook_rsa_symbol_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [rsc_pkg::DATA_W-1:0] i_data_in,
    output logic                       o_result_valid,
    output logic [rsc_pkg::DATA_W-1:0] o_result_value
);

    logic                       r_direction;
    logic [rsc_pkg::DATA_W-1:0] r_exponent;
    logic [rsc_pkg::MOD_W-1:0]  r_modulus;

    logic [rsc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;
    rsc_pkg::t_dp_cmd              cmd;
    rsc_pkg::t_dp_status           status;

    assign reg_idx = paddr[rsc_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_exponent  <= rsc_pkg::DATA_W'(1);
            r_modulus   <= rsc_pkg::MOD_W'(2);
        end else if (wr_en) begin
            unique case (reg_idx)
                rsc_pkg::REG_DIRECTION: r_direction <= pwdata[0];
                rsc_pkg::REG_EXPONENT:  r_exponent  <= pwdata;
                rsc_pkg::REG_MODULUS:   r_modulus   <= pwdata[rsc_pkg::MOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rsc_pkg::REG_DIRECTION: prdata = {31'd0, r_direction};
            rsc_pkg::REG_EXPONENT:  prdata = r_exponent;
            rsc_pkg::REG_MODULUS:   prdata = 32'(r_modulus);
            default:                prdata = '0;
        endcase
    end

    rsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rsc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_data_in      (i_data_in),
        .i_direction    (r_direction),
        .i_exponent     (r_exponent),
        .i_modulus      (r_modulus),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy || $past(start)))
        else $error("result shown while request still running");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a running request");

    a_decrypt_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_direction) |-> (o_result_value[rsc_pkg::DATA_W-1:8] == '0))
        else $error("decrypted result is not a byte");

endmodule

[tb/sv/textbook_rsa_symbol_cipher_tb.sv]
// Self-checking testbench for the RSA symbol cipher: directed table, then random phases (keyed, wild, edge).
module textbook_rsa_symbol_cipher_tb;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 1200;
    localparam int STEADY_TAIL  = 60;
    localparam int N_DIRECTED   = 33;
    localparam logic [rsc_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [8*65-1:0] SYMBOLS =
        "bcdefghijklmnopqrstuvwxyza ABCDEFGHIJKLMNOPQRSTUVWXYZ,.@!?)(*-_%:";

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_ITEM_HIT, ROW_ITEM_NONE} t_row_kind;
    typedef enum int {PH_KEY, PH_WILD, PH_EDGE} t_phase;

    typedef struct packed {
        t_row_kind                         kind;
        logic [rsc_pkg::REG_IDX_W-1:0]     idx;
        logic [31:0]                       val;
        logic [31:0]                       res;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [rsc_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         start;
    logic                         busy;
    logic [rsc_pkg::DATA_W-1:0]   i_data_in;
    logic                         o_result_valid;
    logic [rsc_pkg::DATA_W-1:0]   o_result_value;

    logic                cfg_direction;
    logic [31:0]         cfg_exponent;
    logic [31:0]         cfg_modulus;
    logic [31:0]         pending_results[$];
    logic [31:0]         want;
    int                  fail_count;
    t_row                directed_rows [N_DIRECTED];

    textbook_rsa_symbol_cipher DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_data_in      (i_data_in),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] symbol_at(input int pos);
        return SYMBOLS[8*(64-pos) +: 8];
    endfunction

    function automatic logic [31:0] mod_power(input logic [31:0] base, input logic [31:0] ex,
                                              input logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        int          i;
        if (m < 32'd2) begin
            return '0;
        end
        m64 = {32'd0, m};
        acc = 64'd1;
        sq  = {32'd0, base} % m64;
        for (i = 0; i < 32; i++) begin
            if (ex[i]) begin
                acc = (acc * sq) % m64;
            end
            sq = (sq * sq) % m64;
        end
        return acc[31:0];
    endfunction

    function automatic longint mod_inverse(input longint a, input longint m);
        longint t0;
        longint t1;
        longint r0;
        longint r1;
        longint q;
        longint tmp;
        t0 = 0;
        t1 = 1;
        r0 = m;
        r1 = a;
        while (r1 != 0) begin
            q   = r0 / r1;
            tmp = t0 - q * t1;
            t0  = t1;
            t1  = tmp;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
        end
        if (r0 != 1) begin
            return 0;
        end
        if (t0 < 0) begin
            t0 += m;
        end
        return t0;
    endfunction

    function automatic bit predict_rsa_symbol(input logic [31:0] data, output logic [31:0] value);
        logic [31:0] p;
        int          i;
        value = '0;
        if (cfg_direction == rsc_pkg::DIR_ENCRYPT) begin
            if (data > 32'hFF) begin
                return 1'b0;
            end
            for (i = 0; i < 65; i++) begin
                if ({24'd0, symbol_at(i)} == data) begin
                    value = mod_power(i + rsc_pkg::CODE_FIRST, cfg_exponent, cfg_modulus);
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        p = mod_power(data, cfg_exponent, cfg_modulus);
        if (p < rsc_pkg::CODE_FIRST || p > rsc_pkg::CODE_LAST) begin
            return 1'b0;
        end
        value = {24'd0, symbol_at(p - rsc_pkg::CODE_FIRST)};
        return 1'b1;
    endfunction

    function automatic t_row cfg_row(input logic [rsc_pkg::REG_IDX_W-1:0] idx,
                                     input logic [31:0] val);
        return '{kind: ROW_CFG, idx: idx, val: val, res: '0};
    endfunction

    function automatic t_row item_row(input logic [31:0] data);
        return '{kind: ROW_ITEM, idx: '0, val: data, res: '0};
    endfunction

    function automatic t_row hit_row(input logic [31:0] data, input logic [31:0] res);
        return '{kind: ROW_ITEM_HIT, idx: '0, val: data, res: res};
    endfunction

    function automatic t_row none_row(input logic [31:0] data);
        return '{kind: ROW_ITEM_NONE, idx: '0, val: data, res: '0};
    endfunction

    task automatic reg_write(input logic [rsc_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            rsc_pkg::REG_DIRECTION: cfg_direction = value[0];
            rsc_pkg::REG_EXPONENT:  cfg_exponent  = value;
            rsc_pkg::REG_MODULUS:   cfg_modulus   = value & 32'((64'd1 << rsc_pkg::MOD_W) - 1);
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [31:0] data, input t_row_kind kind,
                                input logic [31:0] res);
        logic [31:0] value;
        bit          hit;
        @(negedge i_clk);
        start     = 1'b1;
        i_data_in = data;
        do @(posedge i_clk); while (busy);
        case (kind)
            ROW_ITEM_HIT: begin
                hit   = 1'b1;
                value = res;
            end
            ROW_ITEM_NONE: begin
                hit   = 1'b0;
                value = '0;
            end
            default: begin
                hit = predict_rsa_symbol(data, value);
            end
        endcase
        if (hit) begin
            pending_results = {pending_results, value};
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // hold off long enough for a request that yields nothing to finish too
    task automatic quiesce();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: got %h", o_result_value);
                end
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (want !== o_result_value) begin
                    if (fail_count < 10) begin
                        $display("result_value mismatch: expected %h, got %h",
                                 want, o_result_value);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int                   k;
        int                   j;
        int                   sent;
        int                   plen;
        bit                   dirty;
        bit                   quiet;
        t_phase               phase;
        logic                 dir;
        longint               n;
        longint               phi;
        longint               e;
        longint               d;
        logic [31:0]          exp_val;
        logic [31:0]          mod_val;
        logic [31:0]          dir_word;
        logic [31:0]          data;
        logic [63:0]          wide;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        start         = 1'b0;
        i_data_in     = '0;
        fail_count    = 0;
        cfg_direction = rsc_pkg::DIR_ENCRYPT;
        cfg_exponent  = 32'd1;
        cfg_modulus   = 32'd2;
        n             = 2;
        e             = 1;

        directed_rows = '{
            hit_row("a", 32'd1),
            hit_row("b", 32'd0),
            hit_row(":", 32'd0),
            hit_row("A", 32'd1),
            hit_row("Z", 32'd0),
            none_row(32'hFFFF_FFFF),
            none_row(32'h0000_0161),
            none_row("0"),
            none_row(32'h0),
            cfg_row(rsc_pkg::REG_MODULUS, 32'd0),
            hit_row("z", 32'd0),
            cfg_row(rsc_pkg::REG_MODULUS, 32'd1),
            hit_row("%", 32'd0),
            cfg_row(rsc_pkg::REG_DIRECTION, 32'(rsc_pkg::DIR_DECRYPT)),
            none_row(32'd5),
            cfg_row(rsc_pkg::REG_MODULUS, 32'd3233),
            cfg_row(rsc_pkg::REG_EXPONENT, 32'd0),
            none_row(32'd7),
            cfg_row(rsc_pkg::REG_DIRECTION, 32'hFFFF_FFFE),
            hit_row("?", 32'd1),
            cfg_row(rsc_pkg::REG_EXPONENT, 32'd17),
            item_row("H"),
            cfg_row(rsc_pkg::REG_DIRECTION, 32'(rsc_pkg::DIR_DECRYPT)),
            cfg_row(rsc_pkg::REG_EXPONENT, 32'd2753),
            item_row(32'hFFFF_FFFF),
            item_row(32'd3232),
            cfg_row(REG_UNUSED, 32'hFFFF_FFFF),
            item_row(32'd1555),
            cfg_row(rsc_pkg::REG_EXPONENT, 32'hFFFF_FFFF),
            cfg_row(rsc_pkg::REG_MODULUS, 32'hFFFF_FFFF),
            cfg_row(rsc_pkg::REG_DIRECTION, 32'(rsc_pkg::DIR_ENCRYPT)),
            item_row("_"),
            item_row(" ")
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        dirty = 1'b0;
        for (k = 0; k < N_DIRECTED; k++) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                if (dirty) begin
                    quiesce();
                end
                dirty = 1'b0;
                reg_write(directed_rows[k].idx, directed_rows[k].val);
            end else begin
                send_request(directed_rows[k].val, directed_rows[k].kind, directed_rows[k].res);
                dirty = 1'b1;
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiesce();
            phase = t_phase'($urandom_range(0, 2));
            dir   = 1'($urandom_range(0, 1));
            case (phase)
                PH_KEY: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            n   = 61 * 53;
                            phi = 60 * 52;
                        end
                        1: begin
                            n   = 251 * 241;
                            phi = 250 * 240;
                        end
                        2: begin
                            n   = 101 * 103;
                            phi = 100 * 102;
                        end
                        default: begin
                            n   = 64'd65521 * 64'd65537;
                            phi = 64'd65520 * 64'd65536;
                        end
                    endcase
                    d = 0;
                    while (d == 0) begin
                        case ($urandom_range(0, 4))
                            0:       e = 3;
                            1:       e = 7;
                            2:       e = 17;
                            3:       e = 257;
                            default: e = 65537;
                        endcase
                        d = mod_inverse(e, phi);
                    end
                    exp_val = (dir == rsc_pkg::DIR_ENCRYPT) ? 32'(e) : 32'(d);
                    mod_val = 32'(n);
                end
                PH_WILD: begin
                    exp_val = $urandom >> $urandom_range(0, 31);
                    if ($urandom_range(0, 1) == 0) begin
                        mod_val = $urandom >> $urandom_range(0, 31);
                    end else begin
                        mod_val = $urandom_range(2, 400);
                    end
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       exp_val = 32'd0;
                        1:       exp_val = 32'd1;
                        2:       exp_val = 32'hFFFF_FFFF;
                        default: exp_val = 32'h8000_0000;
                    endcase
                    case ($urandom_range(0, 4))
                        0:       mod_val = 32'd0;
                        1:       mod_val = 32'd1;
                        2:       mod_val = 32'd2;
                        3:       mod_val = 32'hFFFF_FFFF;
                        default: mod_val = 32'hFFFF_FFFB;
                    endcase
                end
            endcase
            dir_word    = $urandom;
            dir_word[0] = dir;
            reg_write(rsc_pkg::REG_DIRECTION, dir_word);
            reg_write(rsc_pkg::REG_EXPONENT, exp_val);
            reg_write(rsc_pkg::REG_MODULUS, mod_val);
            if ($urandom_range(0, 4) == 0) begin
                reg_write(REG_UNUSED, $urandom);
            end

            plen  = $urandom_range(15, 50);
            if (RANDOM_ITEMS - sent <= 2 * STEADY_TAIL) begin
                plen = RANDOM_ITEMS - sent;
            end
            quiet = ($urandom_range(0, 2) == 0);
            for (j = 0; j < plen && sent < RANDOM_ITEMS; j++) begin
                if (phase == PH_KEY && dir == rsc_pkg::DIR_DECRYPT
                    && $urandom_range(0, 4) != 0) begin
                    data = mod_power($urandom_range(rsc_pkg::CODE_FIRST, rsc_pkg::CODE_LAST),
                                     32'(e), 32'(n));
                    wide = {32'd0, data} + 64'(n) * $urandom_range(0, 3);
                    if (wide <= 64'hFFFF_FFFF) begin
                        data = wide[31:0];
                    end
                end else if (dir == rsc_pkg::DIR_ENCRYPT && $urandom_range(0, 5) != 0) begin
                    data = {24'd0, symbol_at($urandom_range(0, 64))};
                end else begin
                    case ($urandom_range(0, 3))
                        0:       data = $urandom;
                        1:       data = $urandom_range(0, 255);
                        2:       data = 32'hFFFF_FFFF;
                        default: data = $urandom_range(0, 400);
                    endcase
                end
                send_request(data, ROW_ITEM, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2 || (RANDOM_ITEMS - sent > STEADY_TAIL
                                                 && $urandom_range(0, 60) == 0)) begin
                    drain_results();
                end else if (!quiet && RANDOM_ITEMS - sent > STEADY_TAIL
                             && $urandom_range(0, 2) == 0) begin
                    @(negedge i_clk);
                    start = 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
            end
        end

        quiesce();
        fail_count += pending_results.size();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
